FILE: rtl/fcfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed cell free list allocator package
// Shared types, block geometry constants and size class lookups.
// ----------------------------------------------------------------------------
package fcfl_pkg;

	localparam int MAX_CELLS          = 512;
	localparam int BLOCK_BYTES        = 65536;
	localparam int BLOCK_HEADER_BYTES = 64;
	localparam int CELL_HEADER_BYTES  = 16;
	localparam int NUM_CLASSES        = 11;

	// Field widths of the request and result items
	localparam int MODE_W   = 2;
	localparam int OSIZE_W  = 16;
	localparam int IDX_W    = 9;
	localparam int STATUS_W = 2;
	localparam int OFF_W    = 16;
	localparam int FREED_W  = 10;
	localparam int CLS_W    = 4;

	// Link values run up to MAX_CELLS; a value at or above the cell count marks the end of the list
	localparam int LINK_W = $clog2(MAX_CELLS + 1);
	localparam int CB_W   = 11;
	localparam int PROD_W = IDX_W + CB_W;

	localparam int AVAIL_BYTES = (BLOCK_BYTES > BLOCK_HEADER_BYTES) ?
		BLOCK_BYTES - BLOCK_HEADER_BYTES : 0;
	localparam int OBJ_BASE = BLOCK_HEADER_BYTES + CELL_HEADER_BYTES;

	localparam logic [CLS_W-1:0] MAX_CLASS = CLS_W'(NUM_CLASSES - 1);

	function automatic int cap_cells(input int n);
		cap_cells = (n > MAX_CELLS) ? MAX_CELLS : n;
	endfunction

	localparam int unsigned SIZE_TAB [NUM_CLASSES] = '{
		128, 192, 256, 320, 384, 448, 512, 640, 768, 896, 1024
	};

	localparam int unsigned COUNT_TAB [NUM_CLASSES] = '{
		cap_cells(AVAIL_BYTES / 128), cap_cells(AVAIL_BYTES / 192),
		cap_cells(AVAIL_BYTES / 256), cap_cells(AVAIL_BYTES / 320),
		cap_cells(AVAIL_BYTES / 384), cap_cells(AVAIL_BYTES / 448),
		cap_cells(AVAIL_BYTES / 512), cap_cells(AVAIL_BYTES / 640),
		cap_cells(AVAIL_BYTES / 768), cap_cells(AVAIL_BYTES / 896),
		cap_cells(AVAIL_BYTES / 1024)
	};

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_MARK  = 2'd2,
		MODE_SWEEP = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_TOO_LARGE = 2'd2,
		STAT_BAD_CELL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACCESS,
		S_SWEEP,
		S_SWEEP_DONE
	} state_t;

	// One list memory entry
	typedef struct packed {
		logic              used;
		logic              marked;
		logic [LINK_W-1:0] link;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		entry_t             wr_data;
	} ram_req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   granted_cell;
		logic [OFF_W-1:0]   object_offset;
		logic [FREED_W-1:0] freed_count;
	} result_t;

	function automatic logic [CB_W-1:0] cell_bytes(input logic [CLS_W-1:0] c);
		cell_bytes = CB_W'(SIZE_TAB[c]);
	endfunction

	function automatic logic [LINK_W-1:0] cell_count(input logic [CLS_W-1:0] c);
		cell_count = LINK_W'(COUNT_TAB[c]);
	endfunction

endpackage

FILE: rtl/fcfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed cell free list RAM
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fcfl_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/fcfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed cell free list controller
// Sequences list memory reads and write-backs for allocate, free, mark and
// sweep, and keeps the list head, the touched-cell bound and the geometry.
// ----------------------------------------------------------------------------
module fcfl_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  fcfl_pkg::mode_t                  in_mode,
	input  logic [fcfl_pkg::OSIZE_W-1:0]     in_osize,
	input  logic [fcfl_pkg::IDX_W-1:0]       in_idx,
	input  logic                             cfg_we,
	input  logic [fcfl_pkg::CLS_W-1:0]       cfg_wdata,
	input  logic                             out_free,
	output logic                             res_valid,
	output fcfl_pkg::result_t                res,
	output fcfl_pkg::ram_req_t               req,
	input  logic [fcfl_pkg::ENTRY_W-1:0]     rd_data
);

	localparam int LINK_W = fcfl_pkg::LINK_W;
	localparam int IDX_W  = fcfl_pkg::IDX_W;

	fcfl_pkg::state_t state_q, state_d;

	logic [fcfl_pkg::CLS_W-1:0]   size_class_q;
	logic [LINK_W-1:0]            count_q;
	logic [LINK_W-1:0]            head_q;
	// Cells at or above hwm_q were never allocated since the last rebuild
	logic [LINK_W-1:0]            hwm_q;
	logic [LINK_W-1:0]            sw_idx_q;
	logic [fcfl_pkg::FREED_W-1:0] freed_q;
	logic                         sw_v_s1;
	logic [IDX_W-1:0]             sw_at_s1;

	fcfl_pkg::mode_t              mode_q;
	logic [fcfl_pkg::OSIZE_W-1:0] osize_q;
	logic [IDX_W-1:0]             idx_q;

	logic                         accept;
	fcfl_pkg::entry_t             rd;
	logic [fcfl_pkg::CB_W-1:0]    cell_sz;
	logic [fcfl_pkg::CB_W-1:0]    room;
	logic                         too_large;
	logic                         empty;
	logic                         head_fresh;
	logic [LINK_W-1:0]            next_head;
	logic                         idx_used;
	logic                         bad;
	logic [fcfl_pkg::PROD_W-1:0]  prod;
	logic [fcfl_pkg::PROD_W:0]    off_sum;
	logic                         sw_more;
	logic                         sw_hit;
	logic                         sweep_end;
	logic [fcfl_pkg::CLS_W-1:0]   cls_sat;

	logic                         upd_head;
	logic [LINK_W-1:0]            head_new;
	logic                         upd_hwm;

	assign accept     = in_valid && in_ready;
	assign rd         = fcfl_pkg::entry_t'(rd_data);
	assign cell_sz    = fcfl_pkg::cell_bytes(size_class_q);
	assign room       = cell_sz - fcfl_pkg::CB_W'(fcfl_pkg::CELL_HEADER_BYTES);
	assign too_large  = osize_q > fcfl_pkg::OSIZE_W'(room);
	assign empty      = head_q >= count_q;
	assign head_fresh = head_q >= hwm_q;
	assign next_head  = head_fresh ? head_q + LINK_W'(1) : rd.link;
	assign idx_used   = ({1'b0, idx_q} < hwm_q) && rd.used;
	assign bad        = ({1'b0, idx_q} >= count_q) || !idx_used;
	assign prod       = fcfl_pkg::PROD_W'(head_q[IDX_W-1:0]) * fcfl_pkg::PROD_W'(cell_sz);
	assign off_sum    = {1'b0, prod} + (fcfl_pkg::PROD_W + 1)'(fcfl_pkg::OBJ_BASE);
	assign sw_more    = sw_idx_q < count_q;
	assign sw_hit     = sw_v_s1 && ({1'b0, sw_at_s1} < hwm_q) && rd.used && rd.marked;
	assign sweep_end  = !sw_more && !sw_v_s1;
	assign cls_sat    = (cfg_wdata > fcfl_pkg::MAX_CLASS) ? fcfl_pkg::MAX_CLASS : cfg_wdata;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcfl_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (in_mode == fcfl_pkg::MODE_SWEEP) ?
						fcfl_pkg::S_SWEEP : fcfl_pkg::S_ACCESS;
				end
			end
			fcfl_pkg::S_ACCESS: begin
				if (out_free) begin
					state_d = fcfl_pkg::S_IDLE;
				end
			end
			fcfl_pkg::S_SWEEP: begin
				if (sweep_end) begin
					state_d = fcfl_pkg::S_SWEEP_DONE;
				end
			end
			fcfl_pkg::S_SWEEP_DONE: begin
				if (out_free) begin
					state_d = fcfl_pkg::S_IDLE;
				end
			end
			default: state_d = fcfl_pkg::S_IDLE;
		endcase
	end

	// Outputs, memory requests and list updates
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		req       = '0;
		upd_head  = 1'b0;
		head_new  = head_q;
		upd_hwm   = 1'b0;
		case (state_q)
			fcfl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (accept && in_mode != fcfl_pkg::MODE_SWEEP) begin
					req.rd_en   = 1'b1;
					req.rd_addr = (in_mode == fcfl_pkg::MODE_ALLOC) ?
						head_q[IDX_W-1:0] : in_idx;
				end
			end
			fcfl_pkg::S_ACCESS: begin
				res_valid  = 1'b1;
				res.status = fcfl_pkg::STAT_OK;
				case (mode_q)
					fcfl_pkg::MODE_ALLOC: begin
						if (too_large) begin
							res.status = fcfl_pkg::STAT_TOO_LARGE;
						end else if (empty) begin
							res.status = fcfl_pkg::STAT_NO_FREE;
						end else begin
							res.granted_cell  = head_q[IDX_W-1:0];
							res.object_offset = off_sum[fcfl_pkg::OFF_W-1:0];
							// pop: write back the link so a fresh cell keeps it
							req.wr_en       = out_free;
							req.wr_addr     = head_q[IDX_W-1:0];
							req.wr_data     = '{used: 1'b1, marked: 1'b0, link: next_head};
							upd_head        = out_free;
							head_new        = next_head;
							upd_hwm         = out_free && head_fresh;
						end
					end
					fcfl_pkg::MODE_FREE: begin
						if (bad) begin
							res.status = fcfl_pkg::STAT_BAD_CELL;
						end else begin
							req.wr_en   = out_free;
							req.wr_addr = idx_q;
							req.wr_data = '{used: 1'b0, marked: 1'b0, link: head_q};
							upd_head    = out_free;
							head_new    = {1'b0, idx_q};
						end
					end
					fcfl_pkg::MODE_MARK: begin
						if (bad) begin
							res.status = fcfl_pkg::STAT_BAD_CELL;
						end else begin
							req.wr_en   = out_free;
							req.wr_addr = idx_q;
							req.wr_data = '{used: 1'b1, marked: 1'b1, link: rd.link};
						end
					end
					default: begin
					end
				endcase
			end
			fcfl_pkg::S_SWEEP: begin
				req.rd_en   = sw_more;
				req.rd_addr = sw_idx_q[IDX_W-1:0];
				// push the cell read last cycle if it is used and marked
				req.wr_en   = sw_hit;
				req.wr_addr = sw_at_s1;
				req.wr_data = '{used: 1'b0, marked: 1'b0, link: head_q};
				upd_head    = sw_hit;
				head_new    = {1'b0, sw_at_s1};
			end
			fcfl_pkg::S_SWEEP_DONE: begin
				res_valid       = 1'b1;
				res.status      = fcfl_pkg::STAT_OK;
				res.freed_count = freed_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fcfl_pkg::S_IDLE;
			size_class_q <= '0;
			count_q      <= fcfl_pkg::cell_count('0);
			head_q       <= '0;
			hwm_q        <= '0;
			sw_idx_q     <= '0;
			freed_q      <= '0;
			sw_v_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// rebuild: every cell becomes fresh again
				size_class_q <= cls_sat;
				count_q      <= fcfl_pkg::cell_count(cls_sat);
				head_q       <= '0;
				hwm_q        <= '0;
			end else begin
				if (upd_head) begin
					head_q <= head_new;
				end
				if (upd_hwm) begin
					hwm_q <= head_q + LINK_W'(1);
				end
			end
			if (accept && in_mode == fcfl_pkg::MODE_SWEEP) begin
				sw_idx_q <= '0;
				freed_q  <= '0;
			end else if (state_q == fcfl_pkg::S_SWEEP) begin
				if (sw_more) begin
					sw_idx_q <= sw_idx_q + LINK_W'(1);
				end
				if (sw_hit) begin
					freed_q <= freed_q + fcfl_pkg::FREED_W'(1);
				end
			end
			sw_v_s1 <= (state_q == fcfl_pkg::S_SWEEP) && sw_more;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_mode;
			osize_q <= in_osize;
			idx_q   <= in_idx;
		end
		sw_at_s1 <= sw_idx_q[IDX_W-1:0];
	end

`ifndef SYNTH
	a_hwm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q <= count_q)
		else $error("touched-cell bound beyond cell count");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= count_q)
		else $error("free list head beyond cell count");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcfl_pkg::S_IDLE |-> !req.wr_en)
		else $error("list memory written while idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcfl_pkg::S_ACCESS && !out_free && !cfg_we) |=> $stable(head_q))
		else $error("list head changed while result stalled");
`endif

endmodule

FILE: rtl/fixed_cell_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed cell free list allocator
// Allocates, frees, marks and sweeps equal-size cells of one block through a
// linked free list kept in a single list memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                              Contents
// s_*      in         s_tvalid s_tready s_tdata s_tuser  request
// m_*      out        m_tvalid m_tready m_tdata m_tuser  result
// cfg_*    in         cfg_we cfg_wdata                   size class
//
// Allocate, free and mark do a list memory read, then a write-back.
// Sweep reads one list memory entry per cycle over every cell of the block.
// Reset and a size class write rebuild the list at once, no clearing pass.
// A result waits in the output register; a full, stalled output register
// holds the controller in its result state.
// ----------------------------------------------------------------------------
module fixed_cell_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // object_size[15:0], cell_index[24:16]
	input  logic [1:0]  s_tuser,    // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // granted_cell[8:0], object_offset[24:9],
	                                // freed_count[34:25]
	output logic [1:0]  m_tuser,    // status[1:0]
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata   // size_class[3:0]
);

	fcfl_pkg::ram_req_t            req;
	logic [fcfl_pkg::ENTRY_W-1:0]  rd_data;
	fcfl_pkg::result_t             res;
	logic                          res_valid;
	logic                          out_free;

	logic                          m_tvalid_q;
	fcfl_pkg::result_t             res_q;

	assign out_free = !m_tvalid_q || m_tready;

	fcfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (fcfl_pkg::mode_t'(s_tuser)),
		.in_osize  (s_tdata[15:0]),
		.in_idx    (s_tdata[24:16]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.req       (req),
		.rd_data   (rd_data)
	);

	fcfl_ram #(
		.DEPTH (fcfl_pkg::MAX_CELLS),
		.WIDTH (fcfl_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {5'b0, res_q.freed_count, res_q.object_offset, res_q.granted_cell};

endmodule
